FILE: hdl/hkrb_pkg.sv
package hkrb_pkg;

	// Operation codes of one input transaction.
	localparam logic [1:0] OP_PRESS       = 2'd0;
	localparam logic [1:0] OP_RELEASE     = 2'd1;
	localparam logic [1:0] OP_RELEASE_ALL = 2'd2;
	localparam logic [1:0] OP_NONE        = 2'd3;

	// Key types carried in the high byte of the key code.
	localparam logic [7:0] TYPE_ASCII    = 8'h00;
	localparam logic [7:0] TYPE_MOD      = 8'h01;
	localparam logic [7:0] TYPE_NONPRINT = 8'h02;
	localparam logic [7:0] TYPE_SHIFTED  = 8'h03;
	localparam logic [7:0] TYPE_MEDIA    = 8'h80;

	// Left shift in the modifier byte.
	localparam logic [7:0] LSHIFT_MASK = 8'h02;

	// The boot report always carries six key slots.
	localparam int REPORT_SLOTS = 6;

	// ASCII to usage table: bit 8 marks a character that needs left shift.
	localparam int ASCII_DEPTH = 128;
	localparam logic [8:0] ASCII_ROM [ASCII_DEPTH] = '{
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h02a, 9'h02b, 9'h028, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h02c, 9'h11e, 9'h134, 9'h120, 9'h121, 9'h122, 9'h124, 9'h034,
		9'h126, 9'h127, 9'h125, 9'h12e, 9'h036, 9'h02d, 9'h037, 9'h038,
		9'h027, 9'h01e, 9'h01f, 9'h020, 9'h021, 9'h022, 9'h023, 9'h024,
		9'h025, 9'h026, 9'h133, 9'h033, 9'h136, 9'h02e, 9'h137, 9'h138,
		9'h11f, 9'h104, 9'h105, 9'h106, 9'h107, 9'h108, 9'h109, 9'h10a,
		9'h10b, 9'h10c, 9'h10d, 9'h10e, 9'h10f, 9'h110, 9'h111, 9'h112,
		9'h113, 9'h114, 9'h115, 9'h116, 9'h117, 9'h118, 9'h119, 9'h11a,
		9'h11b, 9'h11c, 9'h11d, 9'h02f, 9'h031, 9'h030, 9'h123, 9'h12d,
		9'h035, 9'h004, 9'h005, 9'h006, 9'h007, 9'h008, 9'h009, 9'h00a,
		9'h00b, 9'h00c, 9'h00d, 9'h00e, 9'h00f, 9'h010, 9'h011, 9'h012,
		9'h013, 9'h014, 9'h015, 9'h016, 9'h017, 9'h018, 9'h019, 9'h01a,
		9'h01b, 9'h01c, 9'h01d, 9'h12f, 9'h131, 9'h130, 9'h135, 9'h000
	};

	// Characters above the table read as unmapped.
	function automatic logic [8:0] ascii_lookup(input logic [7:0] idx);
		logic [8:0] entry;
		entry = '0;
		if (!idx[7]) begin
			entry = ASCII_ROM[idx[6:0]];
		end
		return entry;
	endfunction

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] key_code;
	} in_t;

	typedef struct packed {
		logic [15:0] return_code;
		logic [7:0]  modifier_byte;
		logic [7:0]  slot_zero;
		logic [7:0]  slot_one;
		logic [7:0]  slot_two;
		logic [7:0]  slot_three;
		logic [7:0]  slot_four;
		logic [7:0]  slot_five;
		logic [7:0]  media_usage;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

FILE: hdl/hkrb_ctrl.sv
module hkrb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output hkrb_pkg::ctrl_cmd_t cmd
);
	import hkrb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// Next state: each accepted transaction passes through the execute state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	// Commands and handshake outputs.
	assign busy     = (state_q == ST_EXEC);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);
	assign done     = done_q;

endmodule

FILE: hdl/hkrb_datapath.sv
module hkrb_datapath #(
	parameter int NUM_SLOTS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hkrb_pkg::ctrl_cmd_t cmd,
	input  hkrb_pkg::in_t       request,
	output hkrb_pkg::out_t      result
);
	import hkrb_pkg::*;

	in_t        req_q;
	out_t       result_q;
	logic [7:0] mod_q;
	logic [7:0] media_q;
	logic [7:0] slots_q [NUM_SLOTS];

	logic [7:0]  key_type;
	logic [7:0]  low_byte;
	logic [8:0]  rom_entry;
	logic [7:0]  usage;
	logic        shift_hit;
	logic        found;
	logic [15:0] rc_d;
	logic [7:0]  mod_d;
	logic [7:0]  media_d;
	logic [7:0]  slots_d [NUM_SLOTS];
	logic [7:0]  report [REPORT_SLOTS];

	// Capture the transaction when the controller accepts it.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
	end

	// Decode the key and work out the new report.
	always_comb begin
		key_type  = req_q.key_code[15:8];
		low_byte  = req_q.key_code[7:0];
		rom_entry = ascii_lookup(low_byte);
		usage     = low_byte;
		shift_hit = 1'b0;
		if (key_type == TYPE_SHIFTED) begin
			usage     = rom_entry[7:0];
			shift_hit = 1'b1;
		end else if (key_type == TYPE_ASCII) begin
			usage     = rom_entry[7:0];
			shift_hit = rom_entry[8];
		end

		rc_d    = '0;
		mod_d   = mod_q;
		media_d = media_q;
		slots_d = slots_q;
		found   = 1'b0;

		case (req_q.operation)
			OP_PRESS: begin
				if (key_type == TYPE_MOD) begin
					mod_d = mod_q | low_byte;
					rc_d  = req_q.key_code;
				end else if (key_type == TYPE_MEDIA) begin
					if (media_q == 8'h00) begin
						media_d = low_byte;
					end
					rc_d = req_q.key_code;
				end else begin
					if (shift_hit) begin
						mod_d = mod_q | LSHIFT_MASK;
					end
					// The first empty slot takes the usage code.
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!found && slots_q[i] == 8'h00) begin
							slots_d[i] = usage;
							found      = 1'b1;
						end
					end
					if (found) begin
						rc_d = req_q.key_code;
					end
				end
			end
			OP_RELEASE: begin
				if (key_type == TYPE_MOD) begin
					mod_d = mod_q & ~low_byte;
					rc_d  = req_q.key_code;
				end else if (key_type == TYPE_MEDIA) begin
					if (media_q == low_byte) begin
						media_d = 8'h00;
					end
					rc_d = req_q.key_code;
				end else begin
					if (shift_hit) begin
						mod_d = mod_q & ~LSHIFT_MASK;
					end
					// The first slot holding the usage code is emptied.
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!found && slots_q[i] == usage) begin
							slots_d[i] = 8'h00;
							found      = 1'b1;
						end
					end
					if (found) begin
						rc_d = req_q.key_code;
					end
				end
			end
			OP_RELEASE_ALL: begin
				mod_d   = 8'h00;
				media_d = 8'h00;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					slots_d[i] = 8'h00;
				end
			end
			default: begin
			end
		endcase
	end

	// Only the first six slots appear in the report; missing ones read zero.
	for (genvar k = 0; k < REPORT_SLOTS; k++) begin : g_report
		if (k < NUM_SLOTS) begin : g_used
			assign report[k] = slots_d[k];
		end else begin : g_unused
			assign report[k] = 8'h00;
		end
	end

	// Report state, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q   <= 8'h00;
			media_q <= 8'h00;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slots_q[i] <= 8'h00;
			end
		end else if (cmd.exec) begin
			mod_q   <= mod_d;
			media_q <= media_d;
			slots_q <= slots_d;
		end
	end

	// Result register shown during the strobe cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q.return_code   <= rc_d;
			result_q.modifier_byte <= mod_d;
			result_q.slot_zero     <= report[0];
			result_q.slot_one      <= report[1];
			result_q.slot_two      <= report[2];
			result_q.slot_three    <= report[3];
			result_q.slot_four     <= report[4];
			result_q.slot_five     <= report[5];
			result_q.media_usage   <= media_d;
		end
	end

	assign result = result_q;

endmodule

FILE: hdl/hid_keyboard_report_builder_top.sv
// Keyboard report builder: turns press, release and release-all events into a
// boot keyboard report with a modifier byte, six key slots and a media slot.
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low; request carries the operation and the 16-bit key code.
// Output channel: done is high for exactly one cycle, and result holds the
// return code and the whole report after the event during that cycle.
// An accepted transaction enters the execute state; leaving it raises done.
// Busy is high for the single execute cycle in which the slot search and
// table lookup update the report; no new transaction is taken while busy.
// A new transaction may be accepted while the previous result is on the
// result port, since the result sits in its own register.
// The receiver cannot stall: each result is taken in its strobe cycle.
// Reset clears the modifier byte, all key slots and the media slot, and
// leaves the block idle with no result pending.
module hid_keyboard_report_builder_top #(
	parameter int NUM_SLOTS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hkrb_pkg::in_t  request,
	output logic           done,
	output hkrb_pkg::out_t result
);
	import hkrb_pkg::*;

	ctrl_cmd_t cmd;

	hkrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	hkrb_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

endmodule

FILE: hdl/hkrb_checker.sv
module hkrb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input hkrb_pkg::out_t result
);
	import hkrb_pkg::*;

	// An accepted transaction makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// Busy lasts one cycle and is followed by the result strobe.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execute cycle not followed by a result");

	// A result is only shown after an execute cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction");

	// The block stays idle when nothing is started.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy && !done)
		else $error("block became active without a transaction");

	// A strobed result carries only known bits.
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result strobe with unknown bits");

endmodule

bind hid_keyboard_report_builder_top hkrb_checker u_hkrb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
